// ----- rtl/pvcr_pkg.sv -----
// shared types, constants and codes for the mapping entry resolver
`default_nettype none
package pvcr_pkg;

    localparam int MAX_VALUES_DEF    = 16;
    localparam int POSITION_BITS_DEF = 20;

    // widest value entry reported, and least gap that holds a status word
    localparam int VALUE_WIDTH_CLAMP = 64;
    localparam int STATUS_GAP_BITS   = 16;
    localparam int BYTE_SHIFT        = 3;

    localparam int VBYTE_W  = 17;
    localparam int VWIDTH_W = 7;
    localparam int STATB_W  = 18;
    localparam int IMAGE_W  = 20;
    localparam int MEM_W    = VBYTE_W + VWIDTH_W + 16 + 8;

    localparam logic [1:0] KIND_VALUE   = 2'd0;
    localparam logic [1:0] KIND_CHANNEL = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_MISALIGNED = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW   = 2'd2;

    localparam logic [STATB_W-1:0] STATUS_NONE = '1;

    localparam logic REG_SYNC_CHANNEL    = 1'b0;
    localparam logic REG_MIN_VALUE_WIDTH = 1'b1;

    localparam logic [7:0] SYNC_CHANNEL_RST    = 8'd2;
    localparam logic [7:0] MIN_VALUE_WIDTH_RST = 8'd16;

    typedef struct packed {
        logic [7:0] sync_channel;
        logic [7:0] min_value_width;
    } t_cfg;

    // classified entry handed from front to back
    typedef struct packed {
        logic                match;
        logic                is_value;
        logic                mapping_end;
        logic                list_end;
        logic [15:0]         mapping_number;
        logic [15:0]         object_number;
        logic [7:0]          object_sub;
        logic [7:0]          entry_width;
        logic [VWIDTH_W-1:0] value_width;
    } t_op;

    typedef struct packed {
        logic [1:0]          record_kind;
        logic [VBYTE_W-1:0]  value_byte;
        logic [VWIDTH_W-1:0] value_width;
        logic [15:0]         value_object;
        logic [7:0]          value_sub;
        logic [15:0]         channel_mapping;
        logic [STATB_W-1:0]  status_byte;
        logic [IMAGE_W-1:0]  image_size_bits;
        logic [1:0]          result_status;
        logic                last_in_run;
    } t_rec;

endpackage
`default_nettype wire

// ----- rtl/pvcr_front.sv -----
// front end: takes input items and classifies them for the back end
`default_nettype none
module pvcr_front
    import pvcr_pkg::*;
(
    input  wire logic        i_s_valid,
    output logic             o_s_ready,
    input  wire logic [55:0] i_s_data,
    input  wire logic        i_s_mapping_end,
    input  wire logic        i_s_list_end,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_queue_full,
    output logic             o_push,
    output t_op              o_op
);

    logic [7:0] entry_sync;
    logic [7:0] width;

    assign entry_sync = i_s_data[7:0];
    assign width      = i_s_data[55:48];
    assign o_s_ready  = !i_queue_full;
    assign o_push     = i_s_valid && !i_queue_full;

    always_comb begin
        o_op.match          = (entry_sync == i_cfg.sync_channel);
        o_op.is_value       = (width >= i_cfg.min_value_width);
        o_op.mapping_end    = i_s_mapping_end;
        o_op.list_end       = i_s_list_end;
        o_op.mapping_number = i_s_data[23:8];
        o_op.object_number  = i_s_data[39:24];
        o_op.object_sub     = i_s_data[47:40];
        o_op.entry_width    = width;
        if (width > 8'(VALUE_WIDTH_CLAMP)) begin
            o_op.value_width = VWIDTH_W'(VALUE_WIDTH_CLAMP);
        end else begin
            o_op.value_width = width[VWIDTH_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pvcr_queue.sv -----
// two-entry queue of classified items between front and back
`default_nettype none
module pvcr_queue
    import pvcr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_op       o_op
);

    t_op        r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push_ok;
    logic       pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_slot[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr <= !r_wr;
            end
            if (pop_ok) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr] <= i_op;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pvcr_back.sv -----
// back end: bit position tracking, value buffer and record sequencing
`default_nettype none
module pvcr_back
    import pvcr_pkg::*;
#(
    parameter int MAX_VALUES    = MAX_VALUES_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_op_valid,
    input  wire t_op  i_op,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_rec      o_rec
);

    localparam int PB = POSITION_BITS;
    localparam int CW = $clog2(MAX_VALUES + 1);
    localparam int IW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLOSE,
        S_READ,
        S_EMIT,
        S_CHAN,
        S_DONE
    } t_state;

    t_state          r_state;
    logic [PB-1:0]   r_pos;
    logic [PB-1:0]   r_map_start;
    logic [PB-1:0]   r_chan_start;
    logic [PB-1:0]   r_first;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic            r_aligned;
    logic [1:0]      r_fail;
    logic            r_lend;
    logic [15:0]     r_mapping;
    logic            r_o_valid;
    t_rec            r_rec;

    logic [MEM_W-1:0] r_mem [MAX_VALUES];
    logic [MEM_W-1:0] r_rd_data;

    logic [PB-1:0]    n_pos;
    logic [PB-1:0]    n_first;
    logic [CW-1:0]    n_count;
    logic             n_aligned;
    logic [1:0]       n_fail;
    logic             n_close;
    logic             mem_we;
    logic [PB:0]      sum;
    logic [MEM_W-1:0] wr_data;
    logic [PB+VBYTE_W-1:0] pos_wide;
    logic [PB+STATB_W-1:0] chan_wide;
    logic [PB+IMAGE_W-1:0] img_wide;
    logic [PB-1:0]    gap;
    logic             out_free;
    logic             take;
    logic             misaligned;

    assign out_free = !r_o_valid || i_ready;
    assign o_valid  = r_o_valid;
    assign o_rec    = r_rec;
    assign o_pop    = (r_state == S_IDLE);
    assign take     = (r_state == S_IDLE) && i_op_valid;

    assign pos_wide  = {{VBYTE_W{1'b0}}, r_pos} >> BYTE_SHIFT;
    assign chan_wide = {{STATB_W{1'b0}}, r_chan_start} >> BYTE_SHIFT;
    assign img_wide  = {{IMAGE_W{1'b0}}, r_pos};
    assign gap       = r_first - r_chan_start;
    assign wr_data   = {pos_wide[VBYTE_W-1:0], i_op.value_width, i_op.object_number,
                        i_op.object_sub};
    assign misaligned = !r_aligned || (r_map_start[2:0] != 3'd0) || (r_pos[2:0] != 3'd0);

    // state update for one entry, applied when it leaves the queue
    always_comb begin
        n_pos     = r_pos;
        n_first   = r_first;
        n_count   = r_count;
        n_aligned = r_aligned;
        n_fail    = r_fail;
        mem_we    = 1'b0;
        sum       = {1'b0, r_pos} + (PB+1)'(i_op.entry_width);
        if (i_op.match && (r_fail == STAT_OK)) begin
            if (i_op.is_value) begin
                if (r_count == CW'(MAX_VALUES)) begin
                    n_fail = STAT_OVERFLOW;
                end else begin
                    if (r_pos[2:0] != 3'd0) begin
                        n_aligned = 1'b0;
                    end
                    if (r_count == '0) begin
                        n_first = r_pos;
                    end
                    mem_we  = take;
                    n_count = r_count + CW'(1);
                end
            end
            if (n_fail == STAT_OK) begin
                if (sum[PB]) begin
                    n_fail = STAT_OVERFLOW;
                end else begin
                    n_pos = sum[PB-1:0];
                end
            end
        end
        n_close = (n_fail == STAT_OK) &&
                  ((i_op.match && i_op.mapping_end) || i_op.list_end);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[IW-1:0]] <= wr_data;
        end
        r_rd_data <= r_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pos        <= '0;
            r_map_start  <= '0;
            r_chan_start <= '0;
            r_first      <= '0;
            r_count      <= '0;
            r_idx        <= '0;
            r_aligned    <= 1'b1;
            r_fail       <= STAT_OK;
            r_lend       <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (out_free) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_op_valid) begin
                        r_pos     <= n_pos;
                        r_first   <= n_first;
                        r_count   <= n_count;
                        r_aligned <= n_aligned;
                        r_fail    <= n_fail;
                        r_lend    <= i_op.list_end;
                        r_mapping <= i_op.mapping_number;
                        if (n_close) begin
                            r_state <= S_CLOSE;
                        end else if (i_op.list_end) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CLOSE: begin
                    if ((r_fail == STAT_OK) && (r_count != '0) && !misaligned) begin
                        r_idx   <= '0;
                        r_state <= S_READ;
                    end else begin
                        if ((r_fail == STAT_OK) && (r_count != '0)) begin
                            r_fail <= STAT_MISALIGNED;
                        end
                        r_map_start <= r_pos;
                        r_count     <= '0;
                        r_aligned   <= 1'b1;
                        r_state     <= r_lend ? S_DONE : S_IDLE;
                    end
                end
                S_READ: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_rec     <= '0;
                        r_rec.record_kind  <= KIND_VALUE;
                        r_rec.value_byte   <= r_rd_data[MEM_W-1 -: VBYTE_W];
                        r_rec.value_width  <= r_rd_data[MEM_W-VBYTE_W-1 -: VWIDTH_W];
                        r_rec.value_object <= r_rd_data[23:8];
                        r_rec.value_sub    <= r_rd_data[7:0];
                        if (r_idx + CW'(1) == r_count) begin
                            r_state <= S_CHAN;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_CHAN: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_rec     <= '0;
                        r_rec.record_kind     <= KIND_CHANNEL;
                        r_rec.channel_mapping <= r_mapping;
                        if (gap >= PB'(STATUS_GAP_BITS)) begin
                            r_rec.status_byte <= chan_wide[STATB_W-1:0];
                        end else begin
                            r_rec.status_byte <= STATUS_NONE;
                        end
                        r_rec.last_in_run <= !r_lend;
                        r_chan_start <= r_pos;
                        r_map_start  <= r_pos;
                        r_count      <= '0;
                        r_aligned    <= 1'b1;
                        r_state      <= r_lend ? S_DONE : S_IDLE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_rec     <= '0;
                        r_rec.record_kind <= KIND_DONE;
                        if (r_fail == STAT_OK) begin
                            r_rec.image_size_bits <= img_wide[IMAGE_W-1:0];
                        end
                        r_rec.result_status <= r_fail;
                        r_rec.last_in_run   <= 1'b1;
                        // list closed: back to the reset picture
                        r_pos        <= '0;
                        r_map_start  <= '0;
                        r_chan_start <= '0;
                        r_first      <= '0;
                        r_count      <= '0;
                        r_aligned    <= 1'b1;
                        r_fail       <= STAT_OK;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pdo_value_channel_resolver.sv -----
// top level: config registers, front end, queue and back end
//
//  channel   dir  handshake                  carries
//  s_axis    in   i_s_axis_tvalid/tready     one mapping entry
//  m_axis    out  o_m_axis_tvalid/tready     value, channel or done record
//  apb       in   psel/penable, pready=1     sync_channel at 0, min_value_width at 4
//
//  the back end takes an entry from the queue only while idle; an entry that
//  closes a mapping with n aligned buffered values goes through close, a read
//  and an emit per value, then the channel record, and a done record on list end
//  a two-entry queue lets the front keep taking entries while records drain
//  synchronous active-low reset clears all control state; no clearing pass
//  either stream may stall at any cycle
`default_nettype none
module pdo_value_channel_resolver
    import pvcr_pkg::*;
#(
    parameter int MAX_VALUES    = MAX_VALUES_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // entry_sync, mapping_number, object_number, object_sub, entry_width
    input  wire logic [55:0]  i_s_axis_tdata,
    // mapping_end
    input  wire logic         i_s_axis_tuser,
    input  wire logic         i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // value_byte, value_width, value_object, value_sub, channel_mapping,
    // status_byte, image_size_bits, result_status
    output logic [103:0]      o_m_axis_tdata,
    // record_kind
    output logic [1:0]        o_m_axis_tuser,
    output logic              o_m_axis_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg r_cfg;
    logic push;
    logic full;
    logic pop;
    logic q_valid;
    t_op  op_in;
    t_op  op_out;
    t_rec rec;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_channel    <= SYNC_CHANNEL_RST;
            r_cfg.min_value_width <= MIN_VALUE_WIDTH_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_SYNC_CHANNEL:    r_cfg.sync_channel    <= pwdata[7:0];
                REG_MIN_VALUE_WIDTH: r_cfg.min_value_width <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SYNC_CHANNEL:    prdata = {24'd0, r_cfg.sync_channel};
            REG_MIN_VALUE_WIDTH: prdata = {24'd0, r_cfg.min_value_width};
            default:             prdata = '0;
        endcase
    end

    pvcr_front u_front (
        .i_s_valid       (i_s_axis_tvalid),
        .o_s_ready       (o_s_axis_tready),
        .i_s_data        (i_s_axis_tdata),
        .i_s_mapping_end (i_s_axis_tuser),
        .i_s_list_end    (i_s_axis_tlast),
        .i_cfg           (r_cfg),
        .i_queue_full    (full),
        .o_push          (push),
        .o_op            (op_in)
    );

    pvcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (op_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (op_out)
    );

    pvcr_back #(
        .MAX_VALUES    (MAX_VALUES),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_valid),
        .i_op       (op_out),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_rec      (rec)
    );

    assign o_m_axis_tdata = {rec.result_status, rec.image_size_bits, rec.status_byte,
                             rec.channel_mapping, rec.value_sub, rec.value_object,
                             rec.value_width, rec.value_byte};
    assign o_m_axis_tuser = rec.record_kind;
    assign o_m_axis_tlast = rec.last_in_run;

endmodule
`default_nettype wire
